// ===== sv/rau_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Rational arithmetic unit package
// Operation codes, status codes and the word types shared by the project.
// ----------------------------------------------------------------------------
package rau_pkg;

  typedef enum logic [2:0] {
    FN_ADD = 3'd0,
    FN_SUB = 3'd1,
    FN_MUL = 3'd2,
    FN_DIV = 3'd3,
    FN_GT  = 3'd4,
    FN_GTM = 3'd5,
    FN_RSV6 = 3'd6,
    FN_RSV7 = 3'd7
  } func_t;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_INF  = 2'd1,
    ST_DIVZ = 2'd2,
    ST_OVF  = 2'd3
  } status_t;

  typedef struct packed {
    logic [2:0]         func;
    logic signed [31:0] num_a;
    logic [30:0]        den_a;
    logic signed [31:0] num_b;
    logic [30:0]        den_b;
  } in_word_t;

  typedef struct packed {
    logic signed [31:0] res_num;
    logic [30:0]        res_den;
    logic               greater;
    logic [1:0]         status;
  } out_word_t;

endpackage

// ===== sv/rau_in_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Operand channel
// Valid/ready channel carrying one operand word.
// ----------------------------------------------------------------------------
interface rau_in_if;
  logic             valid;
  logic             ready;
  rau_pkg::in_word_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== sv/rau_out_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Result channel
// Valid/ready channel carrying one result word.
// ----------------------------------------------------------------------------
interface rau_out_if;
  logic               valid;
  logic               ready;
  rau_pkg::out_word_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== sv/rational_arithmetic_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Rational arithmetic unit
// Add, subtract, multiply, divide and compare of fractions, gcd reduced.
// ----------------------------------------------------------------------------
// Usage: operand words arrive on in_ch (func, num_a/den_a, num_b/den_b); one
// result word per operand word leaves on out_ch. Both are valid/ready.
// Arithmetic and compare words run through one shared 64-bit adder/subtractor under
// a small sequencer: products are formed by shift-and-add, the gcd by binary
// gcd (one subtract or shift per cycle), and the two divisions by the gcd by
// restoring division. Infinite operands, divide by zero and unused codes go
// straight to the output; compares stop after the products, and arithmetic
// goes on through the gcd and both divisions.
// in_ch.ready is high only while the unit is idle. A finished word sits in
// the output register; while the receiver stalls the unit holds it and takes
// no new word. Reset (rst, synchronous) returns the sequencer to idle and
// drops any pending result.
// ----------------------------------------------------------------------------
module rational_arithmetic_unit #(
  parameter int WIDTH = 32
) (
  input  logic clk,
  input  logic rst,
  rau_in_if.sink    in_ch,
  rau_out_if.source out_ch
);

  typedef enum logic [9:0] {
    S_IDLE = 10'b0000000001,
    S_MUL  = 10'b0000000010,
    S_COMB = 10'b0000000100,
    S_GCDZ = 10'b0000001000,
    S_GCD  = 10'b0000010000,
    S_GSH  = 10'b0000100000,
    S_DIVN = 10'b0001000000,
    S_DIVD = 10'b0010000000,
    S_CHK  = 10'b0100000000,
    S_OUT  = 10'b1000000000
  } state_t;

  localparam logic [63:0] PosMax = (64'd1 << (WIDTH - 1)) - 64'd1;

  state_t state;
  rau_pkg::func_t func;
  logic [63:0] pa, pb;       // first and second product (signed, two's compl)
  logic [63:0] mc, mp;       // multiplicand, multiplier magnitude
  logic        mneg;
  logic [5:0]  cnt;
  logic [1:0]  mul_idx;      // which product: 0 first, 1 second, 2 denominator
  logic [63:0] pd;           // denominator product
  logic        neg;
  logic [63:0] mag, den, gx, gy;
  logic [6:0]  shk;
  logic [63:0] quo, rem, dvs;
  rau_pkg::out_word_t res;
  logic        out_valid;

  // shared adder/subtractor
  logic [63:0] alu_a, alu_b, alu_y;
  logic        alu_sub;
  assign alu_y = alu_sub ? alu_a - alu_b : alu_a + alu_b;

  logic [31:0] abs_a, abs_c;
  assign abs_a = in_ch.data.num_a[31] ? 32'(-in_ch.data.num_a) : in_ch.data.num_a;
  assign abs_c = in_ch.data.num_b[31] ? 32'(-in_ch.data.num_b) : in_ch.data.num_b;

  logic [63:0] rem_sh;
  assign rem_sh = {rem[62:0], quo[63]};

  always_comb begin
    alu_a = '0;
    alu_b = '0;
    alu_sub = 1'b0;
    unique case (state)
      S_MUL: begin
        alu_a = (mul_idx == 2'd0) ? pa : ((mul_idx == 2'd1) ? pb : pd);
        alu_b = mc;
      end
      S_COMB: begin
        alu_a = pa;
        alu_b = pb;
        alu_sub = (func != rau_pkg::FN_ADD);
      end
      S_GCD: begin
        alu_a = (gx > gy) ? gx : gy;
        alu_b = (gx > gy) ? gy : gx;
        alu_sub = 1'b1;
      end
      S_DIVN, S_DIVD: begin
        alu_a = rem_sh;
        alu_b = dvs;
        alu_sub = 1'b1;
      end
      default: ;
    endcase
  end

  assign in_ch.ready  = (state == S_IDLE) && !out_valid;
  assign out_ch.valid = out_valid;
  assign out_ch.data  = res;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ch.ready) out_valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (in_ch.valid && in_ch.ready) begin
            func <= rau_pkg::func_t'(in_ch.data.func);
            res <= '{res_num: '0, res_den: 31'd1, greater: 1'b0, status: rau_pkg::ST_OK};
            if (in_ch.data.func > rau_pkg::FN_GTM) begin
              state <= S_OUT;
            end else if (in_ch.data.den_a == '0 || in_ch.data.den_b == '0) begin
              res <= '{res_num: '0, res_den: '0, greater: 1'b0, status: rau_pkg::ST_INF};
              state <= S_OUT;
            end else if (in_ch.data.func == rau_pkg::FN_DIV && in_ch.data.num_b == '0) begin
              res <= '{res_num: '0, res_den: '0, greater: 1'b0, status: rau_pkg::ST_DIVZ};
              state <= S_OUT;
            end else begin
              // pa = a*(c or d), pb = c*b ; pd = b*d (or b*|c| for divide)
              pa <= '0; pb <= '0; pd <= '0;
              mul_idx <= 2'd0;
              cnt <= '0;
              gx <= {32'd0, abs_a};             // stash operand magnitudes
              gy <= {32'd0, abs_c};
              dvs <= {33'd0, in_ch.data.den_a};
              quo <= {33'd0, in_ch.data.den_b};
              rem <= {62'd0, in_ch.data.num_a[31], in_ch.data.num_b[31]};
              unique case (in_ch.data.func)
                rau_pkg::FN_MUL: begin
                  mc <= {32'd0, abs_a}; mp <= {32'd0, abs_c};
                  mneg <= in_ch.data.num_a[31] ^ in_ch.data.num_b[31];
                end
                rau_pkg::FN_GTM: begin
                  mc <= {32'd0, abs_a}; mp <= {33'd0, in_ch.data.den_b};
                  mneg <= 1'b0;
                end
                default: begin
                  mc <= {32'd0, abs_a}; mp <= {33'd0, in_ch.data.den_b};
                  mneg <= in_ch.data.num_a[31];
                end
              endcase
              state <= S_MUL;
            end
          end
        end
        S_MUL: begin
          // shift-and-add: one multiplier bit a cycle
          if (mp[0]) begin
            unique case (mul_idx)
              2'd0: pa <= alu_y;
              2'd1: pb <= alu_y;
              default: pd <= alu_y;
            endcase
          end
          mc <= {mc[62:0], 1'b0};
          mp <= {1'b0, mp[63:1]};
          cnt <= cnt + 6'd1;
          if (cnt == 6'd31) begin
            cnt <= '0;
            if (mul_idx == 2'd0) begin
              if (mneg) pa <= 64'(-(mp[0] ? alu_y : pa));
              if (func == rau_pkg::FN_MUL) begin
                mul_idx <= 2'd2;
                mc <= dvs; mp <= quo; mneg <= 1'b0;
              end else begin
                mul_idx <= 2'd1;
                mc <= gy; mp <= dvs;
                mneg <= (func == rau_pkg::FN_GTM) ? 1'b0 : rem[0];
              end
            end else if (mul_idx == 2'd1) begin
              if (mneg) pb <= 64'(-(mp[0] ? alu_y : pb));
              if (func == rau_pkg::FN_GT || func == rau_pkg::FN_GTM) begin
                state <= S_COMB;
              end else begin
                mul_idx <= 2'd2;
                mc <= dvs; mp <= quo; mneg <= 1'b0;
                if (func == rau_pkg::FN_DIV) mp <= gy;   // pd = b*|c|
              end
            end else begin
              state <= S_COMB;
            end
          end
        end
        S_COMB: begin
          if (func == rau_pkg::FN_GT || func == rau_pkg::FN_GTM) begin
            res.greater <= alu_y[63] == 1'b0 && alu_y != '0;
            state <= S_OUT;
          end else begin
            logic [63:0] n;
            n = (func == rau_pkg::FN_ADD || func == rau_pkg::FN_SUB) ? alu_y : pa;
            if (func == rau_pkg::FN_DIV && rem[0]) n = 64'(-n);
            neg <= n[63];
            mag <= n[63] ? 64'(-n) : n;
            den <= pd;
            gx <= n[63] ? 64'(-n) : n;
            gy <= pd;
            shk <= '0;
            state <= S_GCDZ;
          end
        end
        S_GCDZ: begin
          if (mag == '0) begin
            res <= '{res_num: '0, res_den: 31'd1, greater: 1'b0, status: rau_pkg::ST_OK};
            state <= S_OUT;
          end else begin
            state <= S_GCD;
          end
        end
        S_GCD: begin
          // binary gcd: strip common twos, then subtract odd values
          if (gx == gy) begin
            gx <= gx;
            state <= S_GSH;
          end else if (!gx[0] && !gy[0]) begin
            gx <= gx >> 1; gy <= gy >> 1; shk <= shk + 7'd1;
          end else if (!gx[0]) begin
            gx <= gx >> 1;
          end else if (!gy[0]) begin
            gy <= gy >> 1;
          end else if (gx > gy) begin
            gx <= alu_y >> 1;
          end else begin
            gy <= alu_y >> 1;
          end
        end
        S_GSH: begin
          if (shk != '0) begin
            gx <= gx << 1; shk <= shk - 7'd1;
          end else begin
            dvs <= gx; quo <= mag; rem <= '0; cnt <= '0;
            state <= S_DIVN;
          end
        end
        S_DIVN, S_DIVD: begin
          // restoring division, one quotient bit a cycle
          if (!alu_y[63] || rem[63]) begin
            rem <= alu_y; quo <= {quo[62:0], 1'b1};
          end else begin
            rem <= rem_sh; quo <= {quo[62:0], 1'b0};
          end
          cnt <= cnt + 6'd1;
          if (cnt == 6'd63) begin
            cnt <= '0;
            rem <= '0;
            if (state == S_DIVN) begin
              mag <= {quo[62:0], !alu_y[63] || rem[63]};
              quo <= den;
              state <= S_DIVD;
            end else begin
              den <= {quo[62:0], !alu_y[63] || rem[63]};
              state <= S_CHK;
            end
          end
        end
        S_CHK: begin
          if (den > PosMax || (neg ? mag > PosMax + 64'd1 : mag > PosMax)) begin
            res <= '{res_num: '0, res_den: '0, greater: 1'b0, status: rau_pkg::ST_OVF};
          end else begin
            res.res_num <= neg ? 32'(-mag) : mag[31:0];
            res.res_den <= den[30:0];
            res.status <= rau_pkg::ST_OK;
          end
          state <= S_OUT;
        end
        S_OUT: begin
          out_valid <= 1'b1;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    in_ch.ready |-> state == S_IDLE && !out_valid) else $error("ready while busy");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ch.ready |=> out_valid && $stable(res)) else $error("result lost");
  a_err_den: assert property (@(posedge clk) disable iff (rst)
    out_valid && res.status != rau_pkg::ST_OK |-> res.res_den == '0)
    else $error("error result with denominator");
  a_out_once: assert property (@(posedge clk) disable iff (rst)
    state == S_OUT |-> !out_valid) else $error("result overrun");
`endif

endmodule
